[hdl/lpht_pkg.sv]
// Shared types, codes and field widths for the linear probing hash table.
`timescale 1ns / 1ps
package lpht_pkg;

	localparam int unsigned SLOTS_DEF     = 16;
	localparam int unsigned KEY_BYTES_DEF = 8;

	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned LEN_W    = 4;
	localparam int unsigned PAY_W    = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SLOTF_W  = 4;
	localparam int unsigned KEYF_W   = 64;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 2'd0,
		FN_LOOKUP = 2'd1,
		FN_DELETE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	// per-slot occupancy codes held in the slot memory
	localparam logic [1:0] ST_EMPTY   = 2'd0;
	localparam logic [1:0] ST_USED    = 2'd1;
	localparam logic [1:0] ST_DELETED = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] RES_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] RES_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] RES_FULL = 2'd2;

endpackage

[hdl/lpht_hash.sv]
// Home slot hash: per key byte h = ((h + b) * b) mod SLOTS.
`timescale 1ns / 1ps
module lpht_hash #(
	parameter int unsigned SLOTS     = lpht_pkg::SLOTS_DEF,
	parameter int unsigned KEY_BYTES = lpht_pkg::KEY_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [KEY_BYTES*8-1:0]            key_in,
	input  logic [lpht_pkg::LEN_W-1:0]        len_in,
	output logic                              done,
	output logic [$clog2(SLOTS)-1:0]          home
);
	import lpht_pkg::*;

	localparam int unsigned SLOT_W = $clog2(SLOTS);
	localparam int unsigned KW     = KEY_BYTES * 8;
	localparam int unsigned AW     = $clog2(SLOTS + 255);
	localparam int unsigned XW     = AW + 8;
	// floor(2^XW / SLOTS): the quotient estimate is low by at most one
	localparam int unsigned RCP    = (1 << XW) / SLOTS;

	typedef enum logic [2:0] {
		H_IDLE,
		H_MUL,
		H_RCP,
		H_SUB,
		H_FIX
	} hstate_t;

	hstate_t           state_q;
	logic [SLOT_W-1:0] h_q;
	logic [KW-1:0]     key_sh_q;
	logic [LEN_W-1:0]  rem_q;
	logic [XW-1:0]     x_q;
	logic [XW-1:0]     q_q;
	logic [XW-1:0]     r_q;

	logic [7:0]        b;
	logic [AW-1:0]     sum;
	logic [XW-1:0]     mul;
	logic [2*XW-1:0]   rcp_prod;
	logic [XW-1:0]     qs;

	assign b        = key_sh_q[7:0];
	assign sum      = AW'(h_q) + AW'(b);
	assign mul      = XW'(sum) * XW'(b);
	assign rcp_prod = (2*XW)'(x_q) * (2*XW)'(RCP);
	assign qs       = q_q * XW'(SLOTS);

	assign done = (state_q == H_MUL) && (rem_q == '0);
	assign home = h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			rem_q   <= '0;
		end else begin
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						h_q      <= '0;
						key_sh_q <= key_in;
						rem_q    <= len_in;
						state_q  <= H_MUL;
					end
				end
				H_MUL: begin
					if (rem_q == '0) begin
						state_q <= H_IDLE;
					end else begin
						x_q      <= mul;
						key_sh_q <= key_sh_q >> 8;
						rem_q    <= rem_q - 1'b1;
						state_q  <= H_RCP;
					end
				end
				H_RCP: begin
					q_q     <= rcp_prod[2*XW-1:XW];
					state_q <= H_SUB;
				end
				H_SUB: begin
					r_q     <= x_q - qs;
					state_q <= H_FIX;
				end
				H_FIX: begin
					if (r_q >= XW'(SLOTS))
						h_q <= SLOT_W'(r_q - XW'(SLOTS));
					else
						h_q <= SLOT_W'(r_q);
					state_q <= H_MUL;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == H_FIX) |-> ((XW+1)'(r_q) < (XW+1)'(2 * SLOTS)))
		else $error("hash remainder out of correction range");

	a_home_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(home) < SLOTS))
		else $error("home slot out of range");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == H_IDLE))
		else $error("hash started while busy");

endmodule

[hdl/linear_probe_hash_table.sv]
// Top level of the linear probing hash table with tombstone deletion.
// One operation at a time. Insert, lookup and delete hash the key one byte at a time in the shared
// multiply/reduce hash unit, then probe 1 to SLOTS slots from the home slot, one read of the slot
// memory per cycle. Clear sweeps the slot memory one entry per cycle. After reset the same sweep
// runs over every slot before the first transfer is taken. A finished result sits in the output
// register, so the next item can be taken while it waits; if that result is still unread when
// the next one finishes, the block holds in its emit state until the output register frees.
`timescale 1ns / 1ps
module linear_probe_hash_table #(
	parameter int unsigned SLOTS     = lpht_pkg::SLOTS_DEF,
	parameter int unsigned KEY_BYTES = lpht_pkg::KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // key_chars[63:0], key_length[67:64], payload[83:68]
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // status[1:0], slot[5:2], found_payload[21:6]
);
	import lpht_pkg::*;

	localparam int unsigned SLOT_W  = $clog2(SLOTS);
	localparam int unsigned KW      = KEY_BYTES * 8;
	localparam int unsigned KEY_LSB = 2;
	localparam int unsigned LEN_LSB = KEY_LSB + KW;
	localparam int unsigned PAY_LSB = LEN_LSB + LEN_W;
	localparam int unsigned WW      = PAY_LSB + PAY_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_EMIT,
		S_SWEEP
	} state_t;

	state_t              state_q;
	func_t               func_q;
	logic [KW-1:0]       key_q;
	logic [LEN_W-1:0]    len_q;
	logic [PAY_W-1:0]    pay_q;
	logic [SLOT_W-1:0]   addr_q;
	logic [SLOT_W-1:0]   cnt_q;
	logic                sweep_emit_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOTF_W-1:0]  res_slot_q;
	logic [PAY_W-1:0]    res_pay_q;
	logic                out_valid_q;
	logic [23:0]         out_data_q;

	logic [WW-1:0]       mem [SLOTS];
	logic [WW-1:0]       rd_q;
	logic [SLOT_W-1:0]   rd_addr;
	logic                wr_en;
	logic [SLOT_W-1:0]   wr_addr;
	logic [WW-1:0]       wr_data;

	logic                accept;
	func_t               func_in;
	logic [LEN_W-1:0]    len_in;
	logic [LEN_W-1:0]    len_sat;
	logic [KW-1:0]       key_m;
	logic                hash_start;
	logic                hash_done;
	logic [SLOT_W-1:0]   hash_home;

	logic [SLOT_W-1:0]   next_addr;
	logic                last_probe;
	logic [1:0]          rd_st;
	logic                rd_match;
	logic [SLOT_W+3:0]   addr_wide;
	logic                out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign func_in       = func_t'(s_axis_tuser);
	assign len_in        = s_axis_tdata[67:64];
	assign len_sat       = (len_in > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : len_in;

	always_comb begin
		key_m = '0;
		for (int i = 0; i < int'(KEY_BYTES); i++) begin
			if (i < int'(len_sat))
				key_m[i*8 +: 8] = s_axis_tdata[i*8 +: 8];
		end
	end

	assign hash_start = accept && (func_in != FN_CLEAR);

	lpht_hash #(
		.SLOTS     (SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key_in (key_m),
		.len_in (len_sat),
		.done   (hash_done),
		.home   (hash_home)
	);

	assign next_addr  = (addr_q == SLOT_W'(SLOTS - 1)) ? '0 : addr_q + 1'b1;
	assign last_probe = (cnt_q == SLOT_W'(SLOTS - 1));
	assign rd_st      = rd_q[1:0];
	assign rd_match   = (rd_q[LEN_LSB +: LEN_W] == len_q) && (rd_q[KEY_LSB +: KW] == key_q);
	assign addr_wide  = {4'b0, addr_q};
	assign out_free   = !out_valid_q || m_axis_tready;

	// home is read while the hash finishes; during probing the next slot is read ahead
	assign rd_addr = (state_q == S_HASH) ? hash_home : next_addr;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		unique case (state_q)
			S_SWEEP: begin
				wr_en = 1'b1;
			end
			S_PROBE: begin
				if (func_q == FN_INSERT) begin
					if (rd_st != ST_USED) begin
						wr_en   = 1'b1;
						wr_data = {pay_q, len_q, key_q, ST_USED};
					end
				end else if (func_q == FN_DELETE) begin
					if (rd_st == ST_USED && rd_match) begin
						wr_en   = 1'b1;
						wr_data = {rd_q[WW-1:2], ST_DELETED};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			addr_q       <= '0;
			cnt_q        <= '0;
			sweep_emit_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= func_in;
						key_q  <= key_m;
						len_q  <= len_sat;
						pay_q  <= s_axis_tdata[83:68];
						if (func_in == FN_CLEAR) begin
							addr_q       <= '0;
							sweep_emit_q <= 1'b1;
							state_q      <= S_SWEEP;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						addr_q  <= hash_home;
						cnt_q   <= '0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (func_q == FN_INSERT) begin
						if (rd_st != ST_USED) begin
							res_status_q <= RES_OK;
							res_slot_q   <= addr_wide[3:0];
							res_pay_q    <= '0;
							state_q      <= S_EMIT;
						end else if (last_probe) begin
							res_status_q <= RES_FULL;
							res_slot_q   <= '0;
							res_pay_q    <= '0;
							state_q      <= S_EMIT;
						end else begin
							addr_q <= next_addr;
							cnt_q  <= cnt_q + 1'b1;
						end
					end else begin
						if (rd_st == ST_EMPTY) begin
							res_status_q <= RES_MISS;
							res_slot_q   <= '0;
							res_pay_q    <= '0;
							state_q      <= S_EMIT;
						end else if (rd_st == ST_USED && rd_match) begin
							res_status_q <= RES_OK;
							res_slot_q   <= addr_wide[3:0];
							res_pay_q    <= rd_q[PAY_LSB +: PAY_W];
							state_q      <= S_EMIT;
						end else if (last_probe) begin
							res_status_q <= RES_MISS;
							res_slot_q   <= '0;
							res_pay_q    <= '0;
							state_q      <= S_EMIT;
						end else begin
							addr_q <= next_addr;
							cnt_q  <= cnt_q + 1'b1;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_data_q <= {2'b0, res_pay_q, res_slot_q, res_status_q};
						state_q    <= S_IDLE;
					end
				end
				S_SWEEP: begin
					if (addr_q == SLOT_W'(SLOTS - 1)) begin
						addr_q <= '0;
						if (sweep_emit_q) begin
							res_status_q <= RES_OK;
							res_slot_q   <= '0;
							res_pay_q    <= '0;
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_PROBE || state_q == S_SWEEP))
		else $error("slot memory written outside probe or sweep");

	a_probe_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && last_probe) |=> (state_q == S_EMIT))
		else $error("probe ran past the table size");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] != RES_OK) |-> (m_axis_tdata[21:2] == '0))
		else $error("slot or payload set on a failed operation");

	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> m_axis_tvalid)
		else $error("result lost on the way to the output register");

endmodule

[verif/linear_probe_hash_table_test.sv]
// Self-checking stream testbench for the linear probing hash table.
`timescale 1ns / 1ps
module linear_probe_hash_table_test;
	import lpht_pkg::*;

	localparam int unsigned N_SLOTS     = SLOTS_DEF;
	localparam int unsigned N_KEY_BYTES = KEY_BYTES_DEF;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOTF_W-1:0]  slot;
		logic [PAY_W-1:0]    payload;
	} reply_t;

	// Predicts each reply from its own copy of the slot memory and matches the block's replies.
	class probe_scoreboard;
		logic [1:0]        occ   [N_SLOTS];
		logic [KEYF_W-1:0] keys  [N_SLOTS];
		logic [LEN_W-1:0]  lens  [N_SLOTS];
		logic [PAY_W-1:0]  pays  [N_SLOTS];
		reply_t            replies_due[$];
		int errors, n_insert, n_lookup, n_delete, n_clear, n_full, n_miss, n_hit;

		function new();
			foreach (occ[j]) occ[j] = ST_EMPTY;
		endfunction

		task report(string what);
			$display("ERROR at %0t ns: %s", $time, what);
			errors++;
		endtask

		function int unsigned home_of(logic [KEYF_W-1:0] key, int unsigned len);
			int unsigned h, b, i;
			h = 0;
			for (i = 0; i < len; i++) begin
				b = 32'(key[8*i +: 8]);
				h = ((h + b) * b) % N_SLOTS;
			end
			return h;
		endfunction

		function void note_request(func_t fn, logic [KEYF_W-1:0] raw_key,
				logic [LEN_W-1:0] raw_len, logic [PAY_W-1:0] pay);
			int unsigned len, h, s, i;
			logic [KEYF_W-1:0] key;
			reply_t r;
			len = (raw_len > N_KEY_BYTES) ? N_KEY_BYTES : raw_len;
			key = (len >= 8) ? raw_key : raw_key & ((64'd1 << (8 * len)) - 64'd1);
			h = home_of(key, len);
			r = '0;
			case (fn)
				FN_CLEAR: begin
					foreach (occ[j]) occ[j] = ST_EMPTY;
					r.status = RES_OK;
					n_clear++;
				end
				FN_INSERT: begin
					n_insert++;
					r.status = RES_FULL;
					for (i = 0; i < N_SLOTS; i++) begin
						s = (h + i) % N_SLOTS;
						if (occ[s] != ST_USED) begin
							occ[s] = ST_USED;
							keys[s] = key;
							lens[s] = LEN_W'(len);
							pays[s] = pay;
							r.status = RES_OK;
							r.slot = SLOTF_W'(s);
							break;
						end
					end
					if (r.status == RES_FULL) n_full++;
				end
				default: begin
					if (fn == FN_DELETE) n_delete++;
					else n_lookup++;
					r.status = RES_MISS;
					for (i = 0; i < N_SLOTS; i++) begin
						s = (h + i) % N_SLOTS;
						if (occ[s] == ST_EMPTY) break;
						if (occ[s] == ST_DELETED) continue;
						if (lens[s] == len && keys[s] == key) begin
							r.status = RES_OK;
							r.slot = SLOTF_W'(s);
							r.payload = pays[s];
							if (fn == FN_DELETE) occ[s] = ST_DELETED;
							break;
						end
					end
					if (r.status == RES_MISS) n_miss++;
					else n_hit++;
				end
			endcase
			replies_due.push_back(r);
		endfunction

		task check_reply(logic [23:0] data);
			reply_t got, want;
			got.status = data[1:0];
			got.slot = data[5:2];
			got.payload = data[21:6];
			if (replies_due.size() == 0) begin
				report($sformatf("reply %h with nothing outstanding", data));
				return;
			end
			want = replies_due.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, predicted %0d", got.status, want.status));
			if (got.slot !== want.slot)
				report($sformatf("slot %0d, predicted %0d", got.slot, want.slot));
			if (got.payload !== want.payload)
				report($sformatf("payload %h, predicted %h", got.payload, want.payload));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;

	probe_scoreboard sb;
	int  items_sent;
	int  burst_left;
	int  next_hold = 400;
	bit  hold_req;

	logic [KEYF_W-1:0] pool_key [12];
	logic [LEN_W-1:0]  pool_len [12];
	int                pool_n;

	linear_probe_hash_table #(
		.SLOTS(N_SLOTS),
		.KEY_BYTES(N_KEY_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_reply(m_axis_tdata);
	end

	// Offer one item from a falling edge until its transfer, then maybe pause between bursts.
	task automatic push_item(input func_t fn, input logic [KEYF_W-1:0] key,
			input logic [LEN_W-1:0] len, input logic [PAY_W-1:0] pay);
		int gap;
		s_axis_tuser = fn;
		s_axis_tdata = {4'b0, pay, len, key};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(fn, key, len, pay);
		items_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Short keys dominate so that home slots collide often.
	function automatic void fresh_key(output logic [KEYF_W-1:0] key, output logic [LEN_W-1:0] len);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) len = '0;
		else if (r < 45) len = LEN_W'($urandom_range(1, 2));
		else if (r < 80) len = LEN_W'($urandom_range(3, 8));
		else len = LEN_W'($urandom_range(9, 15));
		key = {$urandom, $urandom};
	endfunction

	// Same key as a pool entry, with fresh junk past its length and another long-length spelling.
	function automatic void pool_variant(input int idx, output logic [KEYF_W-1:0] key,
			output logic [LEN_W-1:0] len);
		logic [KEYF_W-1:0] mask;
		len = pool_len[idx];
		mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
		key = (pool_key[idx] & mask) | ({$urandom, $urandom} & ~mask);
		if (len >= 8) len = LEN_W'($urandom_range(8, 15));
	endfunction

	task automatic run_episode();
		int k, r, nops, idx;
		logic [KEYF_W-1:0] key;
		logic [LEN_W-1:0]  len;
		if (items_sent >= next_hold) begin
			hold_req = 1'b1;
			next_hold += 700;
		end
		pool_n = $urandom_range(3, 12);
		for (k = 0; k < pool_n; k++) fresh_key(pool_key[k], pool_len[k]);
		if ($urandom_range(0, 3) == 0)
			push_item(FN_CLEAR, {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)),
				PAY_W'($urandom_range(0, 65535)));
		// fill pass: insert 14 to 20 pool keys, which can drive the table past full
		if ($urandom_range(0, 2) == 0) begin
			nops = $urandom_range(14, 20);
			for (k = 0; k < nops; k++) begin
				pool_variant($urandom_range(0, pool_n - 1), key, len);
				push_item(FN_INSERT, key, len, PAY_W'($urandom_range(0, 65535)));
			end
		end
		nops = $urandom_range(15, 40);
		for (k = 0; k < nops; k++) begin
			r = $urandom_range(0, 99);
			idx = $urandom_range(0, pool_n - 1);
			pool_variant(idx, key, len);
			if ($urandom_range(0, 19) == 0) fresh_key(key, len);
			if (r < 30) push_item(FN_INSERT, key, len, PAY_W'($urandom_range(0, 65535)));
			else if (r < 65) push_item(FN_LOOKUP, key, len, PAY_W'($urandom_range(0, 65535)));
			else if (r < 98) push_item(FN_DELETE, key, len, PAY_W'($urandom_range(0, 65535)));
			else push_item(FN_CLEAR, key, len, PAY_W'($urandom_range(0, 65535)));
		end
	endtask

	// Receiver: segments of always-ready, random and periodic stalls, plus long hold-offs on request.
	initial begin
		int seg, mode, k;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			seg = $urandom_range(20, 200);
			for (k = 0; k < seg; k++) begin
				@(negedge clk);
				if (hold_req) begin
					m_axis_tready = 1'b0;
					repeat (400) @(negedge clk);
					hold_req = 1'b0;
				end
				case (mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = 1'($urandom_range(0, 1));
					2: m_axis_tready = ($urandom_range(0, 7) != 0);
					default: m_axis_tready = ((k % 16) < 10);
				endcase
			end
		end
	end

	initial begin
		#10_000_000;
		$display("timeout: replies still outstanding or input never accepted");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FN_INSERT;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty and full-width keys, saturated length, junk past length, tombstones
		push_item(FN_CLEAR,  '1, 4'd15, 16'hFFFF);
		push_item(FN_INSERT, 64'h0, 4'd0, 16'h0000);
		push_item(FN_INSERT, 64'h0, 4'd1, 16'h0F0F);
		push_item(FN_INSERT, '1, 4'd8, 16'hFFFF);
		push_item(FN_INSERT, 64'h0123_4567_89AB_CDEF, 4'd15, 16'h1234);
		push_item(FN_INSERT, 64'h0000_0000_00C3_B2A1, 4'd3, 16'h00AA);
		push_item(FN_LOOKUP, 64'hFFFF_0000_FFFF_0000, 4'd0, 16'h0);
		push_item(FN_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, 16'h0);
		push_item(FN_LOOKUP, '1, 4'd8, 16'h0);
		push_item(FN_LOOKUP, 64'h0123_4567_89AB_CDEF, 4'd12, 16'h0);
		push_item(FN_LOOKUP, 64'hDEAD_BEEF_00C3_B2A1, 4'd3, 16'h0);
		push_item(FN_LOOKUP, 64'h0000_0000_00C3_B2A1, 4'd2, 16'h0);
		push_item(FN_DELETE, '1, 4'd8, 16'h0);
		push_item(FN_LOOKUP, '1, 4'd8, 16'h0);
		push_item(FN_DELETE, '1, 4'd8, 16'h0);
		push_item(FN_LOOKUP, 64'h0123_4567_89AB_CDEF, 4'd8, 16'h0);
		push_item(FN_INSERT, '1, 4'd15, 16'h5555);
		push_item(FN_LOOKUP, '1, 4'd9, 16'hAAAA);
		push_item(FN_DELETE, 64'h0, 4'd0, 16'h0);
		push_item(FN_LOOKUP, 64'h0, 4'd1, 16'h0);
		push_item(FN_CLEAR,  64'h0, 4'd0, 16'h0);
		push_item(FN_LOOKUP, 64'h0, 4'd1, 16'h0);

		while (items_sent < 1570) run_episode();

		s_axis_tvalid = 1'b0;
		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("covered %0d transfers: %0d inserts (%0d full), %0d lookups, %0d deletes, %0d clears",
			items_sent, sb.n_insert, sb.n_full, sb.n_lookup, sb.n_delete, sb.n_clear);
		$display("searches: %0d hits, %0d misses; %0d mismatches",
			sb.n_hit, sb.n_miss, sb.errors);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
